// ----- hdl/stb_pkg.sv -----
// Shared types and constants for the software timer bank.
package stb_pkg;

    localparam int OP_W     = 3;
    localparam int ID_W     = 2;
    localparam int RV_W     = 32;
    localparam int MASK_W   = 4;
    localparam int IDX_W    = 2;
    localparam int TOTAL_W  = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 3'd0,
        OP_CREATE       = 3'd1,
        OP_CREATE_START = 3'd2,
        OP_START        = 3'd3,
        OP_STOP         = 3'd4,
        OP_RESTART      = 3'd5,
        OP_DELETE       = 3'd6,
        OP_NONE         = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } dp_cmd_t;

endpackage

// ----- hdl/stb_ctrl.sv -----
// Controller state machine: input handshake, slot scan sequencing and result register valid.
module stb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              scan_done,
    output stb_pkg::dp_cmd_t  cmd
);

    stb_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= stb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            stb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = stb_pkg::ST_SCAN;
                end
            end
            stb_pkg::ST_SCAN: begin
                cmd.step = 1'b1;
                if (scan_done) begin
                    state_next = stb_pkg::ST_OUT;
                end
            end
            stb_pkg::ST_OUT: begin
                // The result register may still hold the previous word.
                if (!out_valid_reg || m_tready) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stb_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    a_load_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == stb_pkg::ST_SCAN)
        else $error("accepted word did not start a scan");

    a_scan_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stb_pkg::ST_SCAN) && !scan_done |=> state_reg == stb_pkg::ST_SCAN)
        else $error("scan ended before the last slot");

    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stb_pkg::ST_OUT) && out_valid_reg && !m_tready
        |=> state_reg == stb_pkg::ST_OUT)
        else $error("result overwrote an unread word");

endmodule

// ----- hdl/stb_datapath.sv -----
// Datapath: slot flags, reload and countdown registers, tick count and result register.
module stb_datapath #(
    parameter int NUM_TIMERS  = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [stb_pkg::OP_W-1:0]    in_operation,
    input  logic [stb_pkg::ID_W-1:0]    in_timer_id,
    input  logic [stb_pkg::RV_W-1:0]    in_reload_value,
    input  logic                        in_periodic,
    input  stb_pkg::dp_cmd_t            cmd,
    output logic                        scan_done,
    output logic [stb_pkg::MASK_W-1:0]  res_mask,
    output logic                        res_ok,
    output logic [stb_pkg::IDX_W-1:0]   res_idx,
    output logic [stb_pkg::TOTAL_W-1:0] res_count
);

    localparam int PTR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    stb_pkg::op_t              op_reg;
    logic                      id_ok_reg;
    logic [COUNT_WIDTH-1:0]    rv_reg;
    logic                      per_reg;
    logic [PTR_W-1:0]          ptr_reg;

    logic [NUM_TIMERS-1:0]     valid_reg;
    logic [NUM_TIMERS-1:0]     run_reg;
    logic [NUM_TIMERS-1:0]     per_slot_reg;
    logic [COUNT_WIDTH-1:0]    reload_reg [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0]    cd_reg     [NUM_TIMERS];
    logic [stb_pkg::TOTAL_W-1:0] total_reg;

    logic [stb_pkg::MASK_W-1:0]  mask_reg;
    logic                        ok_reg;
    logic [stb_pkg::IDX_W-1:0]   idx_reg;
    logic [stb_pkg::MASK_W-1:0]  out_mask_reg;
    logic                        out_ok_reg;
    logic [stb_pkg::IDX_W-1:0]   out_idx_reg;
    logic [stb_pkg::TOTAL_W-1:0] out_count_reg;

    stb_pkg::op_t              in_op;
    logic                      in_id_ok;
    logic                      is_create;
    logic                      is_multi;
    logic                      last_slot;
    logic [stb_pkg::IDX_W-1:0] slot_lo;
    logic                      slot_in_mask;

    always_comb begin
        in_op        = stb_pkg::op_t'(in_operation);
        in_id_ok     = 32'(in_timer_id) < NUM_TIMERS;
        is_create    = (op_reg == stb_pkg::OP_CREATE) || (op_reg == stb_pkg::OP_CREATE_START);
        is_multi     = is_create || (op_reg == stb_pkg::OP_TICK);
        last_slot    = ptr_reg == PTR_W'(NUM_TIMERS - 1);
        slot_lo      = stb_pkg::IDX_W'(ptr_reg);
        slot_in_mask = 32'(ptr_reg) < stb_pkg::MASK_W;
        // A create stops at the first free slot it meets.
        scan_done    = !is_multi || last_slot || (is_create && !valid_reg[ptr_reg]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            run_reg      <= '0;
            per_slot_reg <= '0;
            total_reg    <= '0;
            ptr_reg      <= '0;
        end else begin
            if (cmd.load) begin
                op_reg    <= in_op;
                id_ok_reg <= in_id_ok;
                rv_reg    <= COUNT_WIDTH'(in_reload_value);
                per_reg   <= in_periodic;
                mask_reg  <= '0;
                ok_reg    <= 1'b0;
                idx_reg   <= '0;
                if (in_op == stb_pkg::OP_TICK || in_op == stb_pkg::OP_CREATE
                        || in_op == stb_pkg::OP_CREATE_START || !in_id_ok) begin
                    ptr_reg <= '0;
                end else begin
                    ptr_reg <= PTR_W'(in_timer_id);
                end
                if (in_op == stb_pkg::OP_TICK) begin
                    total_reg <= total_reg + 1'b1;
                end
            end
            if (cmd.step) begin
                case (op_reg)
                    stb_pkg::OP_TICK: begin
                        if (valid_reg[ptr_reg] && run_reg[ptr_reg]) begin
                            if (cd_reg[ptr_reg] != '0) begin
                                cd_reg[ptr_reg] <= cd_reg[ptr_reg] - COUNT_WIDTH'(1);
                            end else begin
                                if (per_slot_reg[ptr_reg]) begin
                                    cd_reg[ptr_reg] <= reload_reg[ptr_reg];
                                end else begin
                                    run_reg[ptr_reg] <= 1'b0;
                                end
                                if (slot_in_mask) begin
                                    mask_reg[slot_lo] <= 1'b1;
                                end
                            end
                        end
                    end
                    stb_pkg::OP_CREATE, stb_pkg::OP_CREATE_START: begin
                        if (!valid_reg[ptr_reg]) begin
                            reload_reg[ptr_reg]   <= rv_reg;
                            cd_reg[ptr_reg]       <= rv_reg;
                            per_slot_reg[ptr_reg] <= per_reg;
                            run_reg[ptr_reg]      <= (op_reg == stb_pkg::OP_CREATE_START);
                            valid_reg[ptr_reg]    <= 1'b1;
                            ok_reg                <= 1'b1;
                            idx_reg               <= slot_lo;
                        end
                    end
                    stb_pkg::OP_START: begin
                        if (id_ok_reg) begin
                            run_reg[ptr_reg] <= 1'b1;
                        end
                    end
                    stb_pkg::OP_STOP: begin
                        if (id_ok_reg) begin
                            run_reg[ptr_reg] <= 1'b0;
                        end
                    end
                    stb_pkg::OP_RESTART: begin
                        if (id_ok_reg) begin
                            cd_reg[ptr_reg]  <= reload_reg[ptr_reg];
                            run_reg[ptr_reg] <= 1'b1;
                        end
                    end
                    stb_pkg::OP_DELETE: begin
                        if (id_ok_reg) begin
                            valid_reg[ptr_reg] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!scan_done) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            if (cmd.emit) begin
                out_mask_reg  <= mask_reg;
                out_ok_reg    <= ok_reg;
                out_idx_reg   <= idx_reg;
                out_count_reg <= total_reg;
            end
        end
    end

    assign res_mask  = out_mask_reg;
    assign res_ok    = out_ok_reg;
    assign res_idx   = out_idx_reg;
    assign res_count = out_count_reg;

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < NUM_TIMERS)
        else $error("slot pointer ran past the bank");

    a_mask_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && (op_reg != stb_pkg::OP_TICK) |-> mask_reg == '0)
        else $error("expiry bits set by a command other than tick");

    a_ok_create: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && ok_reg |-> is_create)
        else $error("allocation reported without a create");

endmodule

// ----- hdl/soft_timer_bank.sv -----
// Top level of the software timer bank: stream ports, controller and datapath.
//
// Usage: each word on the s_ channel is one command. s_tuser carries the operation
// (tick, create, create and start, start, stop, restart, delete); s_tdata carries the
// timer id, the reload interval and the periodic flag. Every command returns exactly
// one word on the m_ channel with the expiry mask of a tick, the allocation outcome of
// a create and the running tick count.
// Timing: a word is taken, then the controller walks the slots one per cycle through
// the shared slot update logic, then loads the result register. A tick walks every
// slot, a create stops at the first free slot and every other command visits only
// its own slot; one command is in flight at a time.
// The next command is taken as soon as the result sits in the output register, even
// while m_tready is low. If the receiver stalls long enough that a second result is
// ready before the first is taken, the controller holds it until the register frees.
// Reset clears all slot flags, the tick count and m_tvalid; reload and
// countdown values of a slot are not defined until it is created.
module soft_timer_bank #(
    parameter int NUM_TIMERS  = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: timer_id [1:0], reload_value [33:2], periodic [34], zero [39:35]
    input  logic [stb_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: operation [2:0]
    input  logic [stb_pkg::OP_W-1:0]       s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: expired_mask [3:0], alloc_ok [4], alloc_index [6:5], ms_count [38:7],
    // zero [39]
    output logic [stb_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    stb_pkg::dp_cmd_t              cmd;
    logic                          scan_done;
    logic [stb_pkg::MASK_W-1:0]    res_mask;
    logic                          res_ok;
    logic [stb_pkg::IDX_W-1:0]     res_idx;
    logic [stb_pkg::TOTAL_W-1:0]   res_count;

    stb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .scan_done (scan_done),
        .cmd       (cmd)
    );

    stb_datapath #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_operation    (s_tuser),
        .in_timer_id     (s_tdata[1:0]),
        .in_reload_value (s_tdata[33:2]),
        .in_periodic     (s_tdata[34]),
        .cmd             (cmd),
        .scan_done       (scan_done),
        .res_mask        (res_mask),
        .res_ok          (res_ok),
        .res_idx         (res_idx),
        .res_count       (res_count)
    );

    assign m_tdata = {1'b0, res_count, res_idx, res_ok, res_mask};

endmodule

// ----- tb/sv/stb_checker.sv -----
`timescale 1ns / 100ps
// Checker for the software timer bank: predicts each reply word and compares it.
module stb_checker
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    output int                    fail_count,
    output int                    pending_count,
    output logic [NUM_TIMERS-1:0] reload_written
);

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic               ok;
        logic [IDX_W-1:0]   idx;
        logic [TOTAL_W-1:0] count;
    } timer_reply_t;

    logic [NUM_TIMERS-1:0] bank_valid;
    logic [NUM_TIMERS-1:0] bank_running;
    logic [NUM_TIMERS-1:0] bank_periodic;
    logic [RV_W-1:0]       bank_reload [NUM_TIMERS];
    logic [RV_W-1:0]       bank_count  [NUM_TIMERS];
    logic [TOTAL_W-1:0]    ms_total;

    timer_reply_t expected_replies [$];

    task automatic flag_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Applies one command to the bank copy and returns the reply it should produce.
    task automatic advance_timer_bank(input op_t op, input logic [ID_W-1:0] id,
                                      input logic [RV_W-1:0] rv, input logic per,
                                      output timer_reply_t reply);
        logic found;
        reply = '0;
        found = 1'b0;
        case (op)
            OP_TICK: begin
                ms_total = ms_total + 1;
                for (int s = 0; s < NUM_TIMERS; s++) begin
                    if (bank_valid[s] && bank_running[s]) begin
                        if (bank_count[s] != 0) begin
                            bank_count[s] = bank_count[s] - 1;
                        end else begin
                            if (bank_periodic[s])
                                bank_count[s] = bank_reload[s];
                            else
                                bank_running[s] = 1'b0;
                            if (s < MASK_W)
                                reply.mask[s] = 1'b1;
                        end
                    end
                end
            end
            OP_CREATE, OP_CREATE_START: begin
                for (int s = 0; s < NUM_TIMERS; s++) begin
                    if (!found && !bank_valid[s]) begin
                        found            = 1'b1;
                        bank_reload[s]   = rv;
                        bank_count[s]    = rv;
                        bank_periodic[s] = per;
                        bank_running[s]  = (op == OP_CREATE_START);
                        bank_valid[s]    = 1'b1;
                        reload_written[s] = 1'b1;
                        reply.ok         = 1'b1;
                        reply.idx        = IDX_W'(s);
                    end
                end
            end
            OP_START: begin
                if (id < NUM_TIMERS) bank_running[id] = 1'b1;
            end
            OP_STOP: begin
                if (id < NUM_TIMERS) bank_running[id] = 1'b0;
            end
            OP_RESTART: begin
                if (id < NUM_TIMERS) begin
                    bank_count[id]   = bank_reload[id];
                    bank_running[id] = 1'b1;
                end
            end
            OP_DELETE: begin
                if (id < NUM_TIMERS) bank_valid[id] = 1'b0;
            end
            default: begin
            end
        endcase
        reply.count = ms_total;
    endtask

    // Both channels are sampled in one process, so the order within an edge is fixed.
    always @(posedge aclk) begin
        timer_reply_t want;
        timer_reply_t next_reply;
        if (!aresetn) begin
            bank_valid     = '0;
            bank_running   = '0;
            bank_periodic  = '0;
            reload_written = '0;
            ms_total       = '0;
            fail_count     = 0;
            for (int s = 0; s < NUM_TIMERS; s++) begin
                bank_reload[s] = '0;
                bank_count[s]  = '0;
            end
            expected_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: reply word expected none, got %0h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    flag_field("expired_mask", 32'(want.mask), 32'(m_tdata[3:0]));
                    flag_field("alloc_ok", 32'(want.ok), 32'(m_tdata[4]));
                    flag_field("alloc_index", 32'(want.idx), 32'(m_tdata[6:5]));
                    flag_field("ms_count", want.count, m_tdata[38:7]);
                    flag_field("pad bit", 32'd0, 32'(m_tdata[39]));
                end
            end
            if (s_tvalid && s_tready) begin
                advance_timer_bank(op_t'(s_tuser), s_tdata[1:0], s_tdata[33:2], s_tdata[34],
                                   next_reply);
                expected_replies.push_back(next_reply);
            end
        end
        pending_count = expected_replies.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the timer bank testbench: clock, reset, command stimulus and verdict.
module tb_top;
    import stb_pkg::*;

    localparam int RANDOM_WORDS = 1400;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = OP_TICK;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    int                  fail_count;
    int                  pending_count;
    logic [3:0]          reload_written;

    int                  burst_left = 0;
    int                  stall_mode = 0;
    int                  stall_phase_left = 0;
    int                  stall_low_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    soft_timer_bank u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    stb_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .reload_written (reload_written)
    );

    // The receiver switches between always ready, coin-flip stalls and long stalls.
    always @(negedge aclk) begin
        if (stall_phase_left == 0) begin
            stall_mode       = $urandom_range(0, 2);
            stall_phase_left = $urandom_range(20, 200);
        end
        stall_phase_left--;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_low_left > 0) begin
                        stall_low_left--;
                        m_tready <= 1'b0;
                    end else if ($urandom_range(0, 3) == 0) begin
                        stall_low_left = $urandom_range(3, 20);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_command(input op_t op, input logic [1:0] id, input logic [31:0] rv,
                                input logic per);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {5'b0, per, rv, id};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Mostly short intervals so that timers actually fire, with the extremes mixed in.
    function automatic logic [31:0] pick_interval();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 32'($urandom_range(0, 5));
        if (roll < 85) return 32'($urandom_range(6, 40));
        if (roll < 95) return 32'($urandom);
        return (roll < 97) ? 32'd0 : 32'hFFFF_FFFF;
    endfunction

    task automatic send_random_command();
        int         roll;
        op_t        op;
        logic [1:0] id;
        roll = $urandom_range(0, 99);
        id   = 2'($urandom_range(0, 3));
        if (roll < 52)      op = OP_TICK;
        else if (roll < 60) op = OP_CREATE;
        else if (roll < 68) op = OP_CREATE_START;
        else if (roll < 76) op = OP_START;
        else if (roll < 82) op = OP_STOP;
        else if (roll < 90) op = OP_RESTART;
        else if (roll < 98) op = OP_DELETE;
        else                op = OP_NONE;
        // A restart reads the stored interval, which exists only once the slot was created.
        if (op == OP_RESTART && !reload_written[id])
            op = OP_START;
        send_command(op, id, pick_interval(), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_command(OP_TICK, 2'd0, 32'd0, 1'b0);
        send_command(OP_NONE, 2'd3, 32'hFFFF_FFFF, 1'b1);
        send_command(OP_CREATE, 2'd0, 32'd0, 1'b1);
        send_command(OP_CREATE_START, 2'd3, 32'hFFFF_FFFF, 1'b0);
        send_command(OP_CREATE_START, 2'd1, 32'd2, 1'b1);
        send_command(OP_CREATE, 2'd2, 32'd1, 1'b0);
        // The bank is full now: neither create may take a slot or start one.
        send_command(OP_CREATE, 2'd0, 32'd7, 1'b1);
        send_command(OP_CREATE_START, 2'd0, 32'd0, 1'b1);
        send_command(OP_START, 2'd0, 32'd0, 1'b0);
        send_command(OP_START, 2'd3, 32'd0, 1'b0);
        repeat (4) send_command(OP_TICK, 2'd0, 32'd0, 1'b0);
        send_command(OP_STOP, 2'd0, 32'd0, 1'b0);
        send_command(OP_RESTART, 2'd3, 32'd0, 1'b0);
        send_command(OP_DELETE, 2'd1, 32'd0, 1'b0);
        send_command(OP_CREATE, 2'd0, 32'h5555_5555, 1'b0);
        send_command(OP_TICK, 2'd0, 32'd0, 1'b0);
        send_command(OP_DELETE, 2'd0, 32'd0, 1'b0);
        // Running flags may be set on a deleted slot; a later plain create clears them again.
        send_command(OP_START, 2'd0, 32'd0, 1'b0);
        send_command(OP_TICK, 2'd0, 32'd0, 1'b0);
        send_command(OP_CREATE, 2'd0, 32'hAAAA_AAAA, 1'b1);
        send_command(OP_TICK, 2'd0, 32'd0, 1'b0);
        send_command(OP_DELETE, 2'd2, 32'd0, 1'b0);
        send_command(OP_DELETE, 2'd3, 32'd0, 1'b0);

        repeat (RANDOM_WORDS) send_random_command();
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- soft_timer_bank.f -----
hdl/stb_pkg.sv
hdl/stb_ctrl.sv
hdl/stb_datapath.sv
hdl/soft_timer_bank.sv
tb/sv/stb_checker.sv
tb/sv/tb_top.sv
